// ----- sv/rcsgq_pkg.sv -----
// shared constants, types and register codes for the crop, scale and gray quantizer
`timescale 1ns / 1ps
`default_nettype none

package rcsgq_pkg;

  // frame geometry
  localparam int unsigned SRC_WIDTH  = 160;
  localparam int unsigned SRC_HEIGHT = 120;
  localparam int unsigned OUT_SIZE   = 96;

  localparam int unsigned CROP_SIDE = (SRC_HEIGHT <= SRC_WIDTH) ? SRC_HEIGHT : SRC_WIDTH;
  localparam int unsigned CROP_X    = (SRC_WIDTH - CROP_SIDE) / 2;
  localparam int unsigned CROP_Y    = (SRC_HEIGHT - CROP_SIDE) / 2;

  // per-target step of the source position: whole part and remainder
  localparam int unsigned STEP_Q = CROP_SIDE / OUT_SIZE;
  localparam int unsigned STEP_R = CROP_SIDE % OUT_SIZE;

  localparam int unsigned COL_W = $clog2(SRC_WIDTH);
  localparam int unsigned ROW_W = $clog2(SRC_HEIGHT);
  localparam int unsigned TGT_W = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;

  // field widths
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned GRAY_W    = 8;
  localparam int unsigned Q_W       = 8;
  localparam int unsigned IDX_W     = 14;
  localparam int unsigned SCALE_W   = 32;
  localparam int unsigned ZP_W      = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 24;

  // arithmetic
  localparam int unsigned LUMA_W  = 16;
  localparam int unsigned WPROD_W = 24;
  localparam int unsigned PROD_W  = GRAY_W + SCALE_W;
  localparam int unsigned RND_W   = PROD_W - 16;
  localparam int unsigned CLMP_W  = 10;
  localparam int unsigned QSUM_W  = 12;

  localparam logic [LUMA_W-1:0]  LUMA_R     = 16'd19595;
  localparam logic [LUMA_W-1:0]  LUMA_G     = 16'd38470;
  localparam logic [LUMA_W-1:0]  LUMA_B     = 16'd7471;
  localparam logic [PROD_W-1:0]  ROUND_HALF = 40'h0000008000;
  localparam logic [CLMP_W-1:0]  CLAMP_MAX  = 10'd1000;
  localparam logic signed [QSUM_W-1:0] Q_MAX = 12'sd127;
  localparam logic signed [QSUM_W-1:0] Q_MIN = -12'sd128;

  // register codes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 1'b1;
  localparam logic [SCALE_W-1:0]   INV_SCALE_RST   = 32'd65536;
  localparam logic [ZP_W-1:0]      ZERO_OFFSET_RST = 8'h80;

  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(OUT_SIZE * OUT_SIZE - 1);

  // controller to datapath: one selected pixel
  typedef struct packed {
    logic             push;
    logic [IDX_W-1:0] index;
    logic             last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic advance;
  } dp_status_t;

  // register write request
  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ----- sv/rcsgq_ctrl.sv -----
// controller: frame position tracking and output pixel selection
`timescale 1ns / 1ps
`default_nettype none

module rcsgq_ctrl import rcsgq_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  input  wire logic       frame_start_i,
  input  wire dp_status_t status_i,
  output logic            s_ready_o,
  output cmd_t            cmd_o
);

  typedef enum logic [1:0] {
    ST_SCAN = 2'b01,
    ST_HOLD = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [COL_W-1:0]   scol_q, scol_d;
  logic [ROW_W-1:0]   srow_q, srow_d;
  logic [TGT_W-1:0]   tcol_q, tcol_d;
  logic [TGT_W-1:0]   trow_q, trow_d;
  logic [COL_W-1:0]   wcol_q, wcol_d;
  logic [ROW_W-1:0]   wrow_q, wrow_d;
  logic [TGT_W-1:0]   crem_q, crem_d;
  logic [TGT_W-1:0]   rrem_q, rrem_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               accept;
  logic               hit;
  logic [COL_W:0]     wcol_sum;
  logic [ROW_W:0]     wrow_sum;
  logic [TGT_W:0]     crem_sum;
  logic [TGT_W:0]     rrem_sum;

  assign s_ready_o = status_i.advance;
  assign accept    = s_valid_i && status_i.advance;

  always_comb begin
    // a frame start restarts everything before the pixel is looked at
    if (frame_start_i) begin
      state_d = ST_SCAN;
      scol_d  = '0;
      srow_d  = '0;
      tcol_d  = '0;
      trow_d  = '0;
      wcol_d  = COL_W'(CROP_X);
      wrow_d  = ROW_W'(CROP_Y);
      crem_d  = '0;
      rrem_d  = '0;
      idx_d   = '0;
    end else begin
      state_d = state_q;
      scol_d  = scol_q;
      srow_d  = srow_q;
      tcol_d  = tcol_q;
      trow_d  = trow_q;
      wcol_d  = wcol_q;
      wrow_d  = wrow_q;
      crem_d  = crem_q;
      rrem_d  = rrem_q;
      idx_d   = idx_q;
    end

    hit = (state_d == ST_SCAN) && (scol_d == wcol_d) && (srow_d == wrow_d);

    cmd_o.push  = accept && hit;
    cmd_o.index = idx_d;
    cmd_o.last  = (tcol_d == TGT_W'(OUT_SIZE - 1)) && (trow_d == TGT_W'(OUT_SIZE - 1));

    wcol_sum = {1'b0, wcol_d} + (COL_W+1)'(STEP_Q);
    crem_sum = {1'b0, crem_d} + (TGT_W+1)'(STEP_R);
    if (crem_sum >= (TGT_W+1)'(OUT_SIZE)) begin
      crem_sum = crem_sum - (TGT_W+1)'(OUT_SIZE);
      wcol_sum = wcol_sum + 1'b1;
    end
    wrow_sum = {1'b0, wrow_d} + (ROW_W+1)'(STEP_Q);
    rrem_sum = {1'b0, rrem_d} + (TGT_W+1)'(STEP_R);
    if (rrem_sum >= (TGT_W+1)'(OUT_SIZE)) begin
      rrem_sum = rrem_sum - (TGT_W+1)'(OUT_SIZE);
      wrow_sum = wrow_sum + 1'b1;
    end

    if (state_d == ST_SCAN) begin
      if (hit) begin
        idx_d = idx_d + 1'b1;
        if (tcol_d == TGT_W'(OUT_SIZE - 1)) begin
          tcol_d = '0;
          wcol_d = COL_W'(CROP_X);
          crem_d = '0;
          if (trow_d == TGT_W'(OUT_SIZE - 1)) begin
            state_d = ST_HOLD;
          end else begin
            trow_d = trow_d + 1'b1;
            wrow_d = wrow_sum[ROW_W-1:0];
            rrem_d = rrem_sum[TGT_W-1:0];
          end
        end else begin
          tcol_d = tcol_d + 1'b1;
          wcol_d = wcol_sum[COL_W-1:0];
          crem_d = crem_sum[TGT_W-1:0];
        end
      end
      // advance the source position, frame end parks the controller
      if (scol_d == COL_W'(SRC_WIDTH - 1)) begin
        scol_d = '0;
        if (srow_d == ROW_W'(SRC_HEIGHT - 1)) begin
          state_d = ST_HOLD;
        end else begin
          srow_d = srow_d + 1'b1;
        end
      end else begin
        scol_d = scol_d + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SCAN;
      scol_q  <= '0;
      srow_q  <= '0;
      tcol_q  <= '0;
      trow_q  <= '0;
      wcol_q  <= COL_W'(CROP_X);
      wrow_q  <= ROW_W'(CROP_Y);
      crem_q  <= '0;
      rrem_q  <= '0;
      idx_q   <= '0;
    end else if (accept) begin
      state_q <= state_d;
      scol_q  <= scol_d;
      srow_q  <= srow_d;
      tcol_q  <= tcol_d;
      trow_q  <= trow_d;
      wcol_q  <= wcol_d;
      wrow_q  <= wrow_d;
      crem_q  <= crem_d;
      rrem_q  <= rrem_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rcsgq_dp.sv -----
// datapath: luma weighting, scaling, rounding, saturation and output register
`timescale 1ns / 1ps
`default_nettype none

module rcsgq_dp import rcsgq_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [PIX_W-1:0] pixel_i,
  input  wire cmd_t             cmd_i,
  input  wire cfg_wr_t          cfg_i,
  input  wire logic             m_ready_i,
  output dp_status_t            status_o,
  output logic                  m_valid_o,
  output logic [Q_W-1:0]        m_gray_o,
  output logic [IDX_W-1:0]      m_index_o,
  output logic                  m_last_o
);

  logic                 advance;
  logic [SCALE_W-1:0]   inv_scale_q;
  logic [ZP_W-1:0]      zero_off_q;

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic [IDX_W-1:0]     idx1_q, idx2_q, idx3_q, idx4_q;
  logic                 last1_q, last2_q, last3_q, last4_q;

  logic [7:0]           r8, g8, b8;
  logic [WPROD_W-1:0]   pr_q, pg_q, pb_q;
  logic [WPROD_W+1:0]   lsum;
  logic [GRAY_W-1:0]    gray_q;
  logic [PROD_W-1:0]    prod_q;
  logic [PROD_W-1:0]    rsum;
  logic [RND_W-1:0]     rnd;
  logic [CLMP_W-1:0]    clamped;
  logic signed [QSUM_W-1:0] qsum;
  logic [Q_W-1:0]       q_d, q_q;

  assign advance          = !v4_q || m_ready_i;
  assign status_o.advance = advance;

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_scale_q <= INV_SCALE_RST;
      zero_off_q  <= ZERO_OFFSET_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_INV_SCALE:   inv_scale_q <= cfg_i.data[SCALE_W-1:0];
        CFG_ZERO_OFFSET: zero_off_q  <= cfg_i.data[ZP_W-1:0];
        default: ;
      endcase
    end
  end

  // expand to 8 bit channels
  assign r8 = {pixel_i[15:11], 3'b000};
  assign g8 = {pixel_i[10:5], 2'b00};
  assign b8 = {pixel_i[4:0], 3'b000};

  assign lsum = {2'b00, pr_q} + {2'b00, pg_q} + {2'b00, pb_q};

  // round half up, clamp, add zero point, saturate to int8
  always_comb begin
    rsum    = prod_q + ROUND_HALF;
    rnd     = rsum[PROD_W-1:16];
    clamped = (rnd > RND_W'(CLAMP_MAX)) ? CLAMP_MAX : rnd[CLMP_W-1:0];
    qsum    = $signed({2'b00, clamped})
              + $signed({{(QSUM_W-ZP_W){zero_off_q[ZP_W-1]}}, zero_off_q});
    priority if (qsum > Q_MAX) begin
      q_d = Q_MAX[Q_W-1:0];
    end else if (qsum < Q_MIN) begin
      q_d = Q_MIN[Q_W-1:0];
    end else begin
      q_d = qsum[Q_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (advance) begin
      v1_q <= cmd_i.push;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pr_q    <= {16'b0, r8} * {8'b0, LUMA_R};
      pg_q    <= {16'b0, g8} * {8'b0, LUMA_G};
      pb_q    <= {16'b0, b8} * {8'b0, LUMA_B};
      idx1_q  <= cmd_i.index;
      last1_q <= cmd_i.last;
      gray_q  <= lsum[23:16];
      idx2_q  <= idx1_q;
      last2_q <= last1_q;
      prod_q  <= {{SCALE_W{1'b0}}, gray_q} * {{GRAY_W{1'b0}}, inv_scale_q};
      idx3_q  <= idx2_q;
      last3_q <= last2_q;
      q_q     <= q_d;
      idx4_q  <= idx3_q;
      last4_q <= last3_q;
    end
  end

  assign m_valid_o = v4_q;
  assign m_gray_o  = q_q;
  assign m_index_o = idx4_q;
  assign m_last_o  = last4_q;

endmodule

`default_nettype wire

// ----- sv/rgb565_crop_scale_gray_quantizer_top.sv -----
// top level: center crop, nearest-neighbor downscale and int8 grayscale quantizer
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready       tdata[15:0] pixel_rgb565, tuser frame_start
//  m_axis   out  m_axis_tvalid/tready       tdata[7:0] gray_q, [21:8] out_index, tlast
//  cfg      in   cfg_valid/cfg_ready        cfg_index (0 inv_scale_q16, 1 zero_offset), data
//
// one pixel is taken every cycle while s_axis_tready is high; a selected pixel reaches
// m_axis via the four-stage datapath (luma weights, sum, 8x32 scale multiply, round and
// saturate), which moves as one: a held result stalls all stages and drops s_axis_tready
// reset clears position counters and stage valids and loads the register reset values
// cfg writes are taken every cycle and also reach pixels still in the pipeline,
// so they belong in gaps where no pixel is in flight
`timescale 1ns / 1ps
`default_nettype none

module rgb565_crop_scale_gray_quantizer_top import rcsgq_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // pixel requests
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,  // [15:0] pixel_rgb565
  input  wire logic                 s_axis_tuser_i,  // [0] frame_start
  // quantized results
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0]      m_axis_tdata_o,  // [7:0] gray_q, [21:8] out_index, pad
  output logic                      m_axis_tlast_o,  // frame_last
  // register writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  cmd_t       cmd;
  dp_status_t status;
  cfg_wr_t    cfg_wr;
  logic [Q_W-1:0]   gray;
  logic [IDX_W-1:0] index;

  // register writes never wait
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // position tracking decides which pixels become results
  rcsgq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid_i),
    .frame_start_i (s_axis_tuser_i),
    .status_i      (status),
    .s_ready_o     (s_axis_tready_o),
    .cmd_o         (cmd)
  );

  // gray conversion and quantization pipeline
  rcsgq_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pixel_i   (s_axis_tdata_i[PIX_W-1:0]),
    .cmd_i     (cmd),
    .cfg_i     (cfg_wr),
    .m_ready_i (m_axis_tready_i),
    .status_o  (status),
    .m_valid_o (m_axis_tvalid_o),
    .m_gray_o  (gray),
    .m_index_o (index),
    .m_last_o  (m_axis_tlast_o)
  );

  // pack result fields, lowest field first
  assign m_axis_tdata_o = {(M_TDATA_W - Q_W - IDX_W)'(0), index, gray};

endmodule

`default_nettype wire

// ----- sv/rcsgq_checker.sv -----
// port-level checker for the quantizer top level, with its bind
`timescale 1ns / 1ps
`default_nettype none

module rcsgq_checker import rcsgq_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tready_o,
  input wire logic                 m_axis_tvalid_o,
  input wire logic                 m_axis_tready_i,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic                 m_axis_tlast_o
);

  // a held result keeps its request up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result request dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result payload changed while stalled");

  // input backpressure only comes from a stalled result
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("pixel input stalled without output backpressure");

  // the frame's last result carries the last raster index
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[Q_W +: IDX_W] == LAST_INDEX)
    else $error("frame_last on a result that is not the last pixel");

endmodule

bind rgb565_crop_scale_gray_quantizer_top rcsgq_checker u_rcsgq_checker (.*);

`default_nettype wire

// ----- dv/tb_rgb565_crop_scale_gray_quantizer_top.sv -----
// self-checking bench for the crop, nearest-neighbor scale and int8 gray quantizer top
`timescale 1ns / 1ps

module tb_rgb565_crop_scale_gray_quantizer_top;
  import rcsgq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 16;   // pipeline is four stages deep
  localparam int unsigned HOLD_CYCLES  = 500;  // long receiver hold-off
  localparam int unsigned RANDOM_CHUNK = 200;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;
  logic                 s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tlast_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_req      = 1'b0;
  logic        hold_done     = 1'b0;

  rgb565_crop_scale_gray_quantizer_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  typedef struct packed {
    logic signed [Q_W-1:0] gray_q;
    logic [IDX_W-1:0]      out_index;
    logic                  frame_last;
  } gray_result_t;

  // tracks frame position and register values, queues the quantized pixel each request selects
  class quant_scoreboard;
    gray_result_t          pending_gray[$];
    int unsigned           errors;
    logic [SCALE_W-1:0]    inv_scale;
    logic signed [ZP_W-1:0] zero_off;
    int unsigned           src_col, src_row, tgt_col, tgt_row;

    function new();
      inv_scale  = INV_SCALE_RST;
      zero_off   = ZERO_OFFSET_RST;
      src_col    = 0;
      src_row    = 0;
      tgt_col    = 0;
      tgt_row    = 0;
      errors     = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_INV_SCALE:   inv_scale = data;
        CFG_ZERO_OFFSET: zero_off  = data[ZP_W-1:0];
        default: ;
      endcase
    endfunction

    // q16 luma weights on the 565 fields widened to 8 bits, truncated
    function logic [GRAY_W-1:0] luma(logic [PIX_W-1:0] px);
      logic [31:0] r, g, b, sum;
      r   = {24'd0, px[15:11], 3'b000};
      g   = {24'd0, px[10:5], 2'b00};
      b   = {24'd0, px[4:0], 3'b000};
      sum = r * LUMA_R + g * LUMA_G + b * LUMA_B;
      return sum[23:16];
    endfunction

    // round half up, clamp the scaled value, add the zero point, saturate to int8
    function logic signed [Q_W-1:0] quantize(logic [GRAY_W-1:0] gray);
      logic [63:0] prod;
      logic [63:0] rounded;
      int          q;
      prod    = {56'd0, gray} * {32'd0, inv_scale} + 64'h8000;
      rounded = prod >> 16;
      if (rounded > 64'd1000) rounded = 64'd1000;
      q = int'(rounded[10:0]) + int'(zero_off);
      if (q > 127) q = 127;
      if (q < -128) q = -128;
      return q[Q_W-1:0];
    endfunction

    function void take_pixel(logic [PIX_W-1:0] px, logic start);
      int unsigned  want_col, want_row;
      gray_result_t res;
      if (start) begin
        src_col = 0;
        src_row = 0;
        tgt_col = 0;
        tgt_row = 0;
      end
      // past the frame end the position holds until the next frame start
      if (src_row >= SRC_HEIGHT) return;
      if (tgt_row < OUT_SIZE) begin
        want_col = CROP_X + tgt_col * CROP_SIDE / OUT_SIZE;
        want_row = CROP_Y + tgt_row * CROP_SIDE / OUT_SIZE;
        if (src_col == want_col && src_row == want_row) begin
          res.gray_q     = quantize(luma(px));
          res.out_index  = IDX_W'(tgt_row * OUT_SIZE + tgt_col);
          res.frame_last = (tgt_row == OUT_SIZE - 1) && (tgt_col == OUT_SIZE - 1);
          pending_gray.push_back(res);
          tgt_col++;
          if (tgt_col >= OUT_SIZE) begin
            tgt_col = 0;
            tgt_row++;
          end
        end
      end
      src_col++;
      if (src_col >= SRC_WIDTH) begin
        src_col = 0;
        src_row++;
      end
    endfunction

    function void check_gray(logic [M_TDATA_W-1:0] tdata, logic tlast);
      gray_result_t want;
      if (pending_gray.size() == 0) begin
        $error("unexpected result: out_index %0d gray_q %0d", tdata[21:8], $signed(tdata[7:0]));
        errors++;
        return;
      end
      want = pending_gray.pop_front();
      if (tdata[7:0] !== want.gray_q) begin
        $error("gray_q: expected %0d actual %0d", $signed(want.gray_q), $signed(tdata[7:0]));
        errors++;
      end
      if (tdata[21:8] !== want.out_index) begin
        $error("out_index: expected %0d actual %0d", want.out_index, tdata[21:8]);
        errors++;
      end
      if (tlast !== want.frame_last) begin
        $error("frame_last: expected %0b actual %0b", want.frame_last, tlast);
        errors++;
      end
    endfunction

    function int unsigned backlog();
      return pending_gray.size();
    endfunction
  endclass

  quant_scoreboard sb;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // both handshakes sampled at the edge, result checked before the new pixel is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_gray(m_axis_tdata_o, m_axis_tlast_o);
      if (s_axis_tvalid_i && s_axis_tready_o) sb.take_pixel(s_axis_tdata_i, s_axis_tuser_i);
    end
  end

  // receiver: random stalls, forced low during the hold-off
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) m_axis_tready_i <= 1'b0;
      else m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // counts out the long hold-off once it is requested
  initial begin
    wait (hold_req);
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_done <= 1'b1;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("rgb565_crop_scale_gray_quantizer_top test failed");
    $finish;
  end

  // one pixel request, after random idle cycles
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    s_axis_tuser_i  <= start;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // both registers, valid held high across the two requests
  task automatic write_quant(input logic [SCALE_W-1:0] inv, input logic signed [ZP_W-1:0] zp);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_INV_SCALE;
    cfg_data_i  <= inv;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(CFG_INV_SCALE, inv);
    cfg_index_i <= CFG_ZERO_OFFSET;
    cfg_data_i  <= {{(CFG_DAT_W-ZP_W){zp[ZP_W-1]}}, zp};
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(CFG_ZERO_OFFSET, {{(CFG_DAT_W-ZP_W){zp[ZP_W-1]}}, zp});
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering, wait for every queued result, then let the pipeline empty
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.backlog() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // mostly framed runs of random length, with a few stray frame starts
  task automatic send_random_frames(input int unsigned n_items);
    int unsigned run_left;
    logic        start;
    run_left = 0;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (run_left == 0) begin
        start    = 1'b1;
        run_left = $urandom_range(400, 20);
      end else begin
        start = ($urandom_range(99) < 3);
      end
      run_left--;
      send_pixel(PIX_W'($urandom), start);
    end
  endtask

  initial begin
    sb = new();
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_INV_SCALE;
    cfg_data_i      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values: no start mark on the first frame,
    // extreme pixels on the first selected columns, then a frame start mid-frame
    for (int unsigned k = 0; k < 20; k++) send_pixel(PIX_W'($urandom), 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'h07E0, 1'b0);
    send_pixel(16'h5A5A, 1'b0);  // skipped column
    send_pixel(16'h001F, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    drain();

    // no idling, half scale with a negative zero point
    write_quant(32'h0000_8000, -8'sd64);
    send_random_frames(RANDOM_CHUNK);
    drain();

    // sender idle, largest scale: every nonzero gray saturates high
    send_idle_pct = 83;
    write_quant(32'hFFFF_FFFF, -8'sd128);
    send_random_frames(RANDOM_CHUNK);
    drain();

    // receiver stalling, zero scale with the top zero point
    send_idle_pct = 0;
    stall_pct     = 83;
    write_quant(32'h0000_0000, 8'sd127);
    send_random_frames(RANDOM_CHUNK);
    drain();

    // both idling, random frames under backpressure
    send_idle_pct = 18;
    stall_pct     = 18;
    write_quant(SCALE_W'($urandom_range(32'h0002_0000)), ZP_W'($urandom));
    send_random_frames(RANDOM_CHUNK);
    drain();

    // long receiver hold-off while pixels keep coming, so the input stalls
    send_idle_pct = 0;
    stall_pct     = 0;
    write_quant(SCALE_W'($urandom), ZP_W'($urandom));
    hold_req <= 1'b1;
    for (int unsigned k = 0; k < 300; k++) send_pixel(PIX_W'($urandom), k == 0);
    drain();

    // no idling, random moderate scale
    write_quant(SCALE_W'($urandom_range(32'h0004_0000)), ZP_W'($urandom));
    send_random_frames(RANDOM_CHUNK);
    drain();

    if (sb.errors == 0 && sb.backlog() == 0)
      $display("rgb565_crop_scale_gray_quantizer_top test passed");
    else
      $display("rgb565_crop_scale_gray_quantizer_top test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rcsgq_pkg.sv
sv/rcsgq_ctrl.sv
sv/rcsgq_dp.sv
sv/rgb565_crop_scale_gray_quantizer_top.sv
sv/rcsgq_checker.sv
dv/tb_rgb565_crop_scale_gray_quantizer_top.sv
